// ===== rtl/sit_pkg.sv =====
// Package for the segment intersection test: widths, register map, payload types.
package sit_pkg;

    localparam int COORD_WIDTH        = 16;
    localparam int MARGIN_WIDTH       = 15;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int APB_ADDR_WIDTH     = 3;
    localparam int APB_DATA_WIDTH     = 32;

    localparam logic [MARGIN_WIDTH-1:0] END_MARGIN_RESET = MARGIN_WIDTH'(66);

    // register index (byte address / 4)
    localparam logic REG_END_MARGIN = 1'b0;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_start_x;
        logic signed [COORD_WIDTH-1:0] a_start_y;
        logic signed [COORD_WIDTH-1:0] a_end_x;
        logic signed [COORD_WIDTH-1:0] a_end_y;
        logic signed [COORD_WIDTH-1:0] b_start_x;
        logic signed [COORD_WIDTH-1:0] b_start_y;
        logic signed [COORD_WIDTH-1:0] b_end_x;
        logic signed [COORD_WIDTH-1:0] b_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] cross_x;
        logic signed [COORD_WIDTH-1:0] cross_y;
    } seg_result_t;

endpackage

// ===== rtl/sit_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module sit_divider #(
    parameter int NUM_WIDTH = 52,
    parameter int DEN_WIDTH = 35,
    parameter int QUO_WIDTH = 18
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    output logic [QUO_WIDTH-1:0] quo
);

    localparam int DW = DEN_WIDTH;
    localparam int QW = QUO_WIDTH;

    logic [DW:0]   rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = (DW+1)'(num >> QW);
            assign den_in = den;
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in[DW-1:0], low_in[QW-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (trial - {1'b0, den_in}) : trial;
                den_reg[k] <= den_in;
                low_reg[k] <= low_in << 1;
                quo_reg[k] <= {quo_in[QW-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== rtl/segment_intersection_test_top.sv =====
// Top level of the segment intersection test: pipeline, divider pair, APB register.
//
//  channel   direction  handshake                  payload
//  pair      in         pair_valid / pair_ready    seg_pair_t   (two segments)
//  result    out        result_valid / result_ready seg_result_t (hit, crossing)
//  apb       in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One request enters per cycle unless the pipe holds; the crossing point
// is formed by the one-bit-per-stage divider pair.
// All stages advance together; when the result register is full and not
// taken, the whole pipe holds, so nothing is lost or repeated.
// rst_n clears valid bits and loads end_margin with its reset value.
module segment_intersection_test_top
    import sit_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pair_valid,
    output logic                      pair_ready,
    input  seg_pair_t                 pair,
    output logic                      result_valid,
    input  logic                      result_ready,
    output seg_result_t               result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int MW   = MARGIN_WIDTH;
    localparam int DIFW = CW + 1;             // coordinate differences
    localparam int PRDW = 2 * DIFW;           // one cross product term
    localparam int PW   = PRDW + 1;           // den, s_num, t_num
    localparam int MMAX = (F > MW) ? F : MW;
    localparam int CMPW = PW + MMAX + 2;      // interval compare width
    localparam int NW   = PW + DIFW;          // t_num * dA
    localparam int QW   = CW + 2;             // quotient bits
    localparam int SW   = CW + 3;             // final sum width

    localparam logic signed [MMAX+1:0] ONE = (MMAX+2)'(1) << F;

    // ---------------- configuration register ----------------
    logic [MW-1:0] end_margin_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_END_MARGIN) ? APB_DATA_WIDTH'(end_margin_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            end_margin_reg <= END_MARGIN_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_END_MARGIN)
            end_margin_reg <= pwdata[MW-1:0];
    end

    // ---------------- flow control ----------------
    // Global advance: the result register is empty or being drained.
    logic en;
    assign en         = !result_valid || result_ready;
    assign pair_ready = en;

    // ---------------- stage 1: differences ----------------
    logic                   v1_reg;
    logic signed [DIFW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, dx1_reg, dy1_reg;
    logic signed [CW-1:0]   p0x1_reg, p0y1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg  <= DIFW'(pair.a_end_x) - DIFW'(pair.a_start_x);
            ay1_reg  <= DIFW'(pair.a_end_y) - DIFW'(pair.a_start_y);
            bx1_reg  <= DIFW'(pair.b_end_x) - DIFW'(pair.b_start_x);
            by1_reg  <= DIFW'(pair.b_end_y) - DIFW'(pair.b_start_y);
            dx1_reg  <= DIFW'(pair.a_start_x) - DIFW'(pair.b_start_x);
            dy1_reg  <= DIFW'(pair.a_start_y) - DIFW'(pair.b_start_y);
            p0x1_reg <= pair.a_start_x;
            p0y1_reg <= pair.a_start_y;
        end
    end

    // ---------------- stage 2: six products ----------------
    logic                   v2_reg;
    logic signed [PRDW-1:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [DIFW-1:0] ax2_reg, ay2_reg;
    logic signed [CW-1:0]   p0x2_reg, p0y2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= ax1_reg * by1_reg;
            m2_reg   <= bx1_reg * ay1_reg;
            m3_reg   <= ax1_reg * dy1_reg;
            m4_reg   <= ay1_reg * dx1_reg;
            m5_reg   <= bx1_reg * dy1_reg;
            m6_reg   <= by1_reg * dx1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            p0x2_reg <= p0x1_reg;
            p0y2_reg <= p0y1_reg;
        end
    end

    // ---------------- stage 3: den, s_num, t_num ----------------
    logic                   v3_reg;
    logic signed [PW-1:0]   den3_reg, snum3_reg, tnum3_reg;
    logic signed [DIFW-1:0] ax3_reg, ay3_reg;
    logic signed [CW-1:0]   p0x3_reg, p0y3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den3_reg  <= PW'(m1_reg) - PW'(m2_reg);
            snum3_reg <= PW'(m3_reg) - PW'(m4_reg);
            tnum3_reg <= PW'(m5_reg) - PW'(m6_reg);
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            p0x3_reg  <= p0x2_reg;
            p0y3_reg  <= p0y2_reg;
        end
    end

    // ---------------- stage 4: make den non-negative, flag zero ----------------
    logic                   v4_reg;
    logic                   zero4_reg;
    logic signed [PW-1:0]   den4_reg, snum4_reg, tnum4_reg;
    logic signed [DIFW-1:0] ax4_reg, ay4_reg;
    logic signed [CW-1:0]   p0x4_reg, p0y4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero4_reg <= (den3_reg == '0);
            if (den3_reg < 0)
            begin
                den4_reg  <= -den3_reg;
                snum4_reg <= -snum3_reg;
                tnum4_reg <= -tnum3_reg;
            end
            else
            begin
                den4_reg  <= den3_reg;
                snum4_reg <= snum3_reg;
                tnum4_reg <= tnum3_reg;
            end
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            p0x4_reg <= p0x3_reg;
            p0y4_reg <= p0y3_reg;
        end
    end

    // ---------------- stage 5: bounds and t*dA products ----------------
    logic                   v5_reg;
    logic                   zero5_reg;
    logic signed [CMPW-1:0] lo5_reg, hi5_reg, ss5_reg, ts5_reg;
    logic signed [NW-1:0]   px5_reg, py5_reg;
    logic signed [PW-1:0]   den5_reg;
    logic signed [CW-1:0]   p0x5_reg, p0y5_reg;
    logic signed [MW:0]     marg_s;
    logic signed [MMAX+1:0] one_m;

    assign marg_s = $signed({1'b0, end_margin_reg});
    assign one_m  = ONE - (MMAX+2)'(marg_s);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero5_reg <= zero4_reg;
            lo5_reg   <= CMPW'(marg_s * den4_reg);
            hi5_reg   <= CMPW'(one_m * den4_reg);
            ss5_reg   <= CMPW'(snum4_reg) <<< F;
            ts5_reg   <= CMPW'(tnum4_reg) <<< F;
            px5_reg   <= tnum4_reg * ax4_reg;
            py5_reg   <= tnum4_reg * ay4_reg;
            den5_reg  <= den4_reg;
            p0x5_reg  <= p0x4_reg;
            p0y5_reg  <= p0y4_reg;
        end
    end

    // ---------------- stage 6: hit decision, rounding offset ----------------
    typedef struct packed {
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic signed [CW-1:0] p0x;
        logic signed [CW-1:0] p0y;
    } side_t;

    logic            v6_reg;
    side_t           side6_reg;
    logic [NW-1:0]   numx6_reg, numy6_reg;
    logic [PW-1:0]   den6_reg;
    logic [NW-1:0]   absx, absy, half_den;
    logic            hit5;

    assign absx     = (px5_reg < 0) ? NW'(-px5_reg) : NW'(px5_reg);
    assign absy     = (py5_reg < 0) ? NW'(-py5_reg) : NW'(py5_reg);
    assign half_den = NW'(den5_reg >>> 1);
    assign hit5     = !zero5_reg && (ss5_reg >= lo5_reg) && (ss5_reg <= hi5_reg)
                      && (ts5_reg >= lo5_reg) && (ts5_reg <= hi5_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side6_reg.hit  <= hit5;
            side6_reg.negx <= (px5_reg < 0);
            side6_reg.negy <= (py5_reg < 0);
            side6_reg.p0x  <= p0x5_reg;
            side6_reg.p0y  <= p0y5_reg;
            numx6_reg      <= absx + half_den;
            numy6_reg      <= absy + half_den;
            den6_reg       <= den5_reg;
        end
    end

    // ---------------- divider stages ----------------
    logic [QW-1:0] qx, qy;

    sit_divider #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (PW),
        .QUO_WIDTH (QW)
    ) u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx6_reg),
        .den (den6_reg),
        .quo (qx)
    );

    sit_divider #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (PW),
        .QUO_WIDTH (QW)
    ) u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy6_reg),
        .den (den6_reg),
        .quo (qy)
    );

    // sideband delay line matching the divider latency
    side_t side_reg [QW];
    logic  dv_reg   [QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side6_reg;
            for (int k = 1; k < QW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int k = 0; k < QW; k++)
                dv_reg[k] <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= pair_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            dv_reg[0] <= v6_reg;
            for (int k = 1; k < QW; k++)
                dv_reg[k] <= dv_reg[k-1];
            result_valid <= dv_reg[QW-1];
        end
    end

    // ---------------- final: sign, offset, saturate ----------------
    localparam logic signed [SW-1:0] CMAX = SW'((1 << (CW-1)) - 1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

    side_t                side_q;
    logic signed [SW-1:0] offx, offy, sumx, sumy;
    logic signed [CW-1:0] satx, saty;

    assign side_q = side_reg[QW-1];
    assign offx   = side_q.negx ? -$signed(SW'(qx)) : $signed(SW'(qx));
    assign offy   = side_q.negy ? -$signed(SW'(qy)) : $signed(SW'(qy));
    assign sumx   = SW'(side_q.p0x) + offx;
    assign sumy   = SW'(side_q.p0y) + offy;
    assign satx   = (sumx > CMAX) ? CW'(CMAX) : (sumx < CMIN) ? CW'(CMIN) : CW'(sumx);
    assign saty   = (sumy > CMAX) ? CW'(CMAX) : (sumy < CMIN) ? CW'(CMIN) : CW'(sumy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result.hit     <= side_q.hit;
            result.cross_x <= side_q.hit ? satx : '0;
            result.cross_y <= side_q.hit ? saty : '0;
        end
    end

endmodule

// ===== sim/segment_intersection_test_top_test.sv =====
// Self-checking testbench for the segment intersection test top level.
module segment_intersection_test_top_test;
    import sit_pkg::*;

    localparam int FRAC         = FRACTION_BITS_DEF;
    localparam int LATENCY      = 6 + (COORD_WIDTH + 2) + 1;
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1850;

    logic                      clk;
    logic                      rst_n;
    logic                      pair_valid;
    logic                      pair_ready;
    seg_pair_t                 pair;
    logic                      result_valid;
    logic                      result_ready;
    seg_result_t               result;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    segment_intersection_test_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair         (pair),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // requests waiting for the driver, crossings waiting for the monitor
    seg_pair_t   pending_pairs[$];
    seg_result_t expected_crossings[$];

    // predictor copy of the margin register
    logic [MARGIN_WIDTH-1:0] margin_q;

    int  errors;
    int  stall_cycles;
    int  send_gap;
    int  take_gap;
    bit  send_hold;
    bit  quiet_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Rounded division with den > 0, ties away from zero.
    function automatic longint round_quot(longint num, longint den);
        longint mag;
        begin
            mag = (num < 0) ? -num : num;
            mag = (mag + den / 2) / den;
            return (num < 0) ? -mag : mag;
        end
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
        longint hi_lim;
        longint lo_lim;
        begin
            hi_lim = (longint'(1) << (COORD_WIDTH - 1)) - 1;
            lo_lim = -hi_lim - 1;
            if (v > hi_lim)
                v = hi_lim;
            else if (v < lo_lim)
                v = lo_lim;
            return v[COORD_WIDTH-1:0];
        end
    endfunction

    // Exact crossing test: both parameters must sit inside [m, 1-m].
    function automatic seg_result_t predict_crossing(seg_pair_t p, logic [MARGIN_WIDTH-1:0] m);
        longint ax, ay, bx, by, dx, dy, den, snum, tnum, one, lo_b, hi_b, ss, ts;
        seg_result_t r;
        begin
            r  = '0;
            ax = longint'(p.a_end_x) - longint'(p.a_start_x);
            ay = longint'(p.a_end_y) - longint'(p.a_start_y);
            bx = longint'(p.b_end_x) - longint'(p.b_start_x);
            by = longint'(p.b_end_y) - longint'(p.b_start_y);
            dx = longint'(p.a_start_x) - longint'(p.b_start_x);
            dy = longint'(p.a_start_y) - longint'(p.b_start_y);
            den  = ax * by - bx * ay;
            snum = ax * dy - ay * dx;
            tnum = bx * dy - by * dx;
            one  = longint'(1) << FRAC;
            if (den == 0)
                return r;
            if (den < 0)
            begin
                den  = -den;
                snum = -snum;
                tnum = -tnum;
            end
            lo_b = longint'(m) * den;
            hi_b = (one - longint'(m)) * den;
            ss   = snum * one;
            ts   = tnum * one;
            if (ss >= lo_b && ss <= hi_b && ts >= lo_b && ts <= hi_b)
            begin
                r.hit     = 1'b1;
                r.cross_x = clamp_coord(longint'(p.a_start_x) + round_quot(tnum * ax, den));
                r.cross_y = clamp_coord(longint'(p.a_start_y) + round_quot(tnum * ay, den));
            end
            return r;
        end
    endfunction

    // Short gaps mostly, sometimes long; none at all in quiet stretches.
    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (quiet_mode || roll < 55)
                return 0;
            if (roll < 93)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    // Driver: prediction is made at acceptance, with the margin in force then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
            pair       <= '0;
            send_gap   <= 0;
        end
        else
        begin
            // accepted request leaves the queue before the next one is picked
            if (pair_valid && pair_ready)
            begin
                expected_crossings.push_back(predict_crossing(pair, margin_q));
                void'(pending_pairs.pop_front());
            end
            if (pair_valid && !pair_ready)
                ;
            else if (send_gap > 0)
            begin
                pair_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (!send_hold && pending_pairs.size() > 0)
            begin
                pair_valid <= 1'b1;
                pair       <= pending_pairs[0];
                send_gap   <= pick_gap();
            end
            else
                pair_valid <= 1'b0;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        seg_result_t exp_r;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            take_gap     <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    exp_r = expected_crossings.pop_front();
                    if (result.hit !== exp_r.hit)
                    begin
                        $display("%0t: hit expected %b actual %b", $time, exp_r.hit, result.hit);
                        errors++;
                    end
                    if (result.cross_x !== exp_r.cross_x)
                    begin
                        $display("%0t: cross_x expected %0d actual %0d",
                                 $time, exp_r.cross_x, result.cross_x);
                        errors++;
                    end
                    if (result.cross_y !== exp_r.cross_y)
                    begin
                        $display("%0t: cross_y expected %0d actual %0d",
                                 $time, exp_r.cross_y, result.cross_y);
                        errors++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                result_ready <= 1'b0;
                take_gap     <= take_gap - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                take_gap     <= pick_gap();
            end
        end
    end

    // Watchdog on cycles with no request or result accepted.
    always @(posedge clk)
    begin
        if (!rst_n || (pair_valid && pair_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("segment_intersection_test_top_test NOT OK");
            $finish;
        end
    end

    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        begin
            p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
            return p;
        end
    endfunction

    // Build a pair that crosses somewhere, with random scale and offsets.
    function automatic seg_pair_t crossing_pair();
        seg_pair_t p;
        int span;
        int cx, cy;
        begin
            span = ($urandom_range(0, 9) == 0) ? 16000 : 1500;
            cx = $urandom_range(0, 2 * span) - span;
            cy = $urandom_range(0, 2 * span) - span;
            p.a_start_x = COORD_WIDTH'(cx - $urandom_range(1, span));
            p.a_start_y = COORD_WIDTH'(cy - $urandom_range(0, span));
            p.a_end_x   = COORD_WIDTH'(cx + $urandom_range(1, span));
            p.a_end_y   = COORD_WIDTH'(cy + $urandom_range(0, span));
            p.b_start_x = COORD_WIDTH'(cx - $urandom_range(0, span));
            p.b_start_y = COORD_WIDTH'(cy + $urandom_range(1, span));
            p.b_end_x   = COORD_WIDTH'(cx + $urandom_range(0, span));
            p.b_end_y   = COORD_WIDTH'(cy - $urandom_range(1, span));
            return p;
        end
    endfunction

    function automatic seg_pair_t make_pair(int x0, int y0, int x1, int y1,
                                            int x2, int y2, int x3, int y3);
        seg_pair_t p;
        begin
            p = {COORD_WIDTH'(x0), COORD_WIDTH'(y0), COORD_WIDTH'(x1), COORD_WIDTH'(y1),
                 COORD_WIDTH'(x2), COORD_WIDTH'(y2), COORD_WIDTH'(x3), COORD_WIDTH'(y3)};
            return p;
        end
    endfunction

    task automatic write_margin(logic [MARGIN_WIDTH-1:0] value);
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_WIDTH'(REG_END_MARGIN) << 2;
            pwdata  <= APB_DATA_WIDTH'(value);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            margin_q = value;
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    // Wait until every queued request went out and every result came back.
    task automatic drain();
        begin
            while (pending_pairs.size() != 0 || pair_valid || expected_crossings.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    initial
    begin
        int phase;
        int n;
        int lo_m;
        int hi_m;
        logic [MARGIN_WIDTH-1:0] margins[5];
        errors     = 0;
        send_hold  = 1'b0;
        quiet_mode = 1'b0;
        margin_q   = END_MARGIN_RESET;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset margin, extremes, parallel, degenerate, end touches.
        pending_pairs.push_back(make_pair(-160, 0, 160, 0, 0, -160, 0, 160));
        pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 10, 160, 10));
        pending_pairs.push_back(make_pair(0, 0, 160, 160, 80, 80, 320, 320));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
        pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, -160, 0, 160));
        pending_pairs.push_back(make_pair(0, 0, 160, 0, 160, -160, 160, 160));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                          32767, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(make_pair(0, 0, 3, 1, 1, 0, 0, 3));
        pending_pairs.push_back(make_pair(0, 0, 1, 2, 0, 1, 3, 0));
        pending_pairs.push_back(make_pair(-100, 30, 100, -30, -7, -90, 9, 90));
        // Pause: once every result is back, hold the sender with a request queued.
        drain();
        send_hold = 1'b1;
        pending_pairs.push_back(crossing_pair());
        repeat (10) @(posedge clk);
        send_hold = 1'b0;
        drain();

        // Random phases under several margins, zero and the top among them.
        margins[0] = MARGIN_WIDTH'(0);
        margins[1] = 15'h7fff;
        margins[2] = MARGIN_WIDTH'(32768 - 1);
        margins[3] = MARGIN_WIDTH'(1);
        margins[4] = MARGIN_WIDTH'(66);
        for (phase = 0; phase < 8; phase++)
        begin
            if (phase < 5)
                write_margin(margins[phase]);
            else
            begin
                lo_m = (phase == 7) ? 16000 : 0;
                hi_m = (phase == 7) ? 32767 : 4000;
                write_margin(MARGIN_WIDTH'($urandom_range(lo_m, hi_m)));
            end
            quiet_mode = (phase == 3);
            for (n = 0; n < RANDOM_ITEMS / 8; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    pending_pairs.push_back(rand_pair());
                    2:       pending_pairs.push_back(make_pair(0, 0, 160, 160,
                                 $urandom_range(0, 50), 0, 160 + $urandom_range(0, 50), 160));
                    default: pending_pairs.push_back(crossing_pair());
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("segment_intersection_test_top_test OK");
        else
            $display("segment_intersection_test_top_test NOT OK");
        $finish;
    end

endmodule
